/* rtl/circular_queue_with_search_assert.svh */
// Assertion macros used by the queue's control block, cqs_ctrl
`ifndef CIRCULAR_QUEUE_WITH_SEARCH_ASSERT_SVH
`define CIRCULAR_QUEUE_WITH_SEARCH_ASSERT_SVH

// Check a consequence in the same cycle as its cause
`define CQS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause
`define CQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/cqs_pkg.sv */
// Shared types, constants and helper functions of the circular queue with search
`default_nettype none

package cqs_pkg;

  localparam int DEPTH       = 16;
  localparam int PTR_W       = $clog2(DEPTH);
  localparam int RS_W        = PTR_W + 1;
  localparam int CFG_W       = 5;
  localparam int ID_W        = 31;
  localparam int ACT_W       = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_FLD_W   = 7;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam logic [CFG_W-1:0] ACTIVE_SIZE_RST = CFG_W'(DEPTH);
  localparam logic             REG_ACTIVE_SIZE = 1'b0;

  typedef enum logic [ACT_W-1:0] {
    ACT_ENQ  = 2'd0,
    ACT_DEQ  = 2'd1,
    ACT_FIND = 2'd2
  } act_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } st_e;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [ID_W-1:0]  wdata;
    logic [PTR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic             done;
    logic [PTR_W-1:0] slot;
    logic             empty;
    logic             full;
  } res_t;

  // Clamp the programmed size into 1..DEPTH
  function automatic logic [RS_W-1:0] ring_size(input logic [CFG_W-1:0] a);
    logic [RS_W-1:0] rs;
    if (a == '0) begin
      rs = RS_W'(1);
    end else if (a > CFG_W'(DEPTH)) begin
      rs = RS_W'(DEPTH);
    end else begin
      rs = RS_W'(a);
    end
    return rs;
  endfunction

  // Step a pointer, wrapping to zero at the ring size
  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [RS_W-1:0]  rs);
    logic [RS_W-1:0] q;
    q = {1'b0, p} + RS_W'(1);
    return (q >= rs) ? '0 : q[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/cqs_mem.sv */
// Id store: one write port and one registered read port
`default_nettype none

module cqs_mem (
  input  logic                        clk_i,
  input  cqs_pkg::mem_req_t           req_i,
  output logic [cqs_pkg::ID_W-1:0]    rdata_o
);
  import cqs_pkg::*;

  logic [ID_W-1:0] mem_q [DEPTH];
  logic [ID_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/cqs_ctrl.sv */
// Queue pointers, action decode and the find scan sequencer
`default_nettype none

module cqs_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [cqs_pkg::ACT_W-1:0]   action_i,
  input  logic [cqs_pkg::ID_W-1:0]    user_id_i,
  input  logic [cqs_pkg::RS_W-1:0]    ring_size_i,
  input  logic                        out_free_i,
  output logic                        res_valid_o,
  output cqs_pkg::res_t               res_o,
  output cqs_pkg::mem_req_t           mem_req_o,
  input  logic [cqs_pkg::ID_W-1:0]    mem_rdata_i
);
  import cqs_pkg::*;

  `include "circular_queue_with_search_assert.svh"

  st_e              state_q, state_d;
  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic             empty_q, empty_d;
  logic [PTR_W-1:0] cur_q, cur_d;
  logic [PTR_W-1:0] cnt_q, cnt_d;
  logic [ID_W-1:0]  key_q, key_d;

  logic             in_fire;
  logic             full_now;
  logic             full_after;
  logic             hit;
  logic             scan_end;
  logic [PTR_W-1:0] cur_next;
  logic [PTR_W-1:0] tail_next;

  assign in_ready_o = (state_q == ST_IDLE) && out_free_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign tail_next  = advance(tail_q, ring_size_i);
  assign full_now   = !empty_q && (tail_next == head_q);
  assign full_after = !empty_d && (advance(tail_d, ring_size_i) == head_d);
  assign cur_next   = advance(cur_q, ring_size_i);
  assign hit        = (mem_rdata_i == key_q);
  assign scan_end   = hit || (cur_q == tail_q) || (cnt_q == PTR_W'(DEPTH - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (act_e'(action_i) == ACT_FIND) && !empty_q) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    head_d          = head_q;
    tail_d          = tail_q;
    empty_d         = empty_q;
    cur_d           = cur_q;
    cnt_d           = cnt_q;
    key_d           = key_q;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = tail_next;
    mem_req_o.wdata = user_id_i;
    mem_req_o.raddr = cur_q;
    res_valid_o     = 1'b0;
    res_o.done      = 1'b0;
    res_o.slot      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          res_valid_o = 1'b1;
          case (act_e'(action_i))
            ACT_ENQ: begin
              if (!full_now) begin
                res_o.done   = 1'b1;
                mem_req_o.we = 1'b1;
                if (empty_q) begin
                  head_d          = '0;
                  tail_d          = '0;
                  empty_d         = 1'b0;
                  mem_req_o.waddr = '0;
                end else begin
                  tail_d = tail_next;
                end
              end
            end
            ACT_DEQ: begin
              if (!empty_q) begin
                res_o.done = 1'b1;
                if (head_q == tail_q) begin
                  head_d  = '0;
                  tail_d  = '0;
                  empty_d = 1'b1;
                end else begin
                  head_d = advance(head_q, ring_size_i);
                end
              end
            end
            ACT_FIND: begin
              // Start the scan at the front; the result follows at its end
              if (!empty_q) begin
                res_valid_o     = 1'b0;
                cur_d           = head_q;
                cnt_d           = '0;
                key_d           = user_id_i;
                mem_req_o.raddr = head_q;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          res_valid_o = 1'b1;
          res_o.done  = hit;
          res_o.slot  = hit ? cur_q : '0;
        end else begin
          cur_d           = cur_next;
          cnt_d           = cnt_q + PTR_W'(1);
          mem_req_o.raddr = cur_next;
        end
      end
      default: begin
      end
    endcase

    res_o.empty = empty_d;
    res_o.full  = full_after;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    cnt_q <= cnt_d;
    key_q <= key_d;
  end

  `CQS_ASSERT_NOW(a_empty_ptrs, empty_q, (head_q == '0) && (tail_q == '0), "pointers not at zero while empty")
  `CQS_ASSERT_NOW(a_scan_nonempty, state_q == ST_SCAN, !empty_q, "scan running on empty queue")
  `CQS_ASSERT_NOW(a_scan_out_free, state_q == ST_SCAN, out_free_i, "result register busy during scan")
  `CQS_ASSERT_NOW(a_miss_slot_zero, res_valid_o && !res_o.done, res_o.slot == '0, "slot set on miss")
  `CQS_ASSERT_NEXT(a_res_to_idle, res_valid_o, state_q == ST_IDLE, "not idle after result")

endmodule

`default_nettype wire

/* rtl/circular_queue_with_search.sv */
// Top level of the circular queue with search: stream ports, APB register and result register
//
// Usage:
//  - Input channel s_axis_*: each item carries an action (enqueue, dequeue, find) and a user id.
//    Enqueue stores the id at the rear unless the queue is full; dequeue drops the front entry;
//    find scans from front to rear for the id. Action code 3 changes nothing.
//  - Output channel m_axis_*: exactly one result item per input item, in order: done flag,
//    physical slot of the first match, and the empty and full flags after the action.
//  - APB port: register 0 (byte address 0) holds active_size, the number of ring slots in use,
//    clamped to 1..16. Write it only while the block is idle.
// Timing:
//  - Enqueue, dequeue and unused action: the result is registered and shows in the cycle after the item.
//  - Find: the item is accepted, then the slots are visited from the front (1..16, none on an
//    empty queue) through the single read port of the id store, one slot per cycle.
//  - One item is in work at a time; the next item is taken once the result register is empty
//    or its result is taken in the same cycle.
// Reset: the queue is empty, both pointers are zero, active_size is 16. The id store is not
//  cleared; an entry is only read after it has been written, unless active_size changes while entries are held.
// Stall: while m_axis_tready is low and a result is held, s_axis_tready stays low.
`default_nettype none

module circular_queue_with_search (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input items
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [cqs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // action[1:0], user_id[32:2], zero
  // Result items
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [cqs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // done_res[0], found_slot[4:1],
                                                            // empty_res[5], full_res[6], zero
  // Configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [cqs_pkg::APB_AW-1:0]         paddr,
  input  logic [cqs_pkg::APB_DW-1:0]         pwdata,
  output logic [cqs_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);
  import cqs_pkg::*;

  logic [CFG_W-1:0] active_size_q, active_size_d;
  logic             out_valid_q, out_valid_d;
  res_t             out_q, out_d;

  logic             cfg_wr;
  logic             out_free;
  logic             res_valid;
  res_t             res;
  mem_req_t         mem_req;
  logic [ID_W-1:0]  mem_rdata;
  logic [RS_W-1:0]  rs;

  // APB register: writes complete in the access phase, no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[APB_AW-1] == REG_ACTIVE_SIZE) ? APB_DW'(active_size_q) : '0;

  always_comb begin
    active_size_d = active_size_q;
    if (cfg_wr && (paddr[APB_AW-1] == REG_ACTIVE_SIZE)) begin
      active_size_d = pwdata[CFG_W-1:0];
    end
  end

  assign rs = ring_size(active_size_q);

  // Result register: load a new result, else drop the held one once taken
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_size_q <= ACTIVE_SIZE_RST;
      out_valid_q   <= 1'b0;
    end else begin
      active_size_q <= active_size_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FLD_W){1'b0}},
                          out_q.full, out_q.empty, out_q.slot, out_q.done};

  cqs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (s_axis_tdata[ACT_W-1:0]),
    .user_id_i   (s_axis_tdata[ACT_W+ID_W-1:ACT_W]),
    .ring_size_i (rs),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  cqs_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

/* tb/queue_result_checker.sv */
// Checker for the circular queue: predicts every result item and compares it with the block
`timescale 1ns / 100ps

module queue_result_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [cqs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // action[1:0], user_id[32:2], zero
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [cqs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // done[0], slot[4:1], empty[5],
                                                          // full[6], zero
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cqs_pkg::APB_AW-1:0]      paddr,
  input  logic [cqs_pkg::APB_DW-1:0]      pwdata,
  input  logic [cqs_pkg::APB_DW-1:0]      prdata,
  input  logic                            pready,
  output int                              fail_count,
  output int                              pending_results
);

  import cqs_pkg::*;

  localparam int                MAX_SHOWN = 10;
  localparam logic [APB_AW-1:0] SIZE_ADDR = APB_AW'(4 * int'(REG_ACTIVE_SIZE));

  // Same bit order as the result tdata, lowest field last
  typedef struct packed {
    logic             full;
    logic             empty;
    logic [PTR_W-1:0] slot;
    logic             done;
  } queue_result_t;

  logic [ID_W-1:0]  id_store [DEPTH];
  logic [PTR_W-1:0] front;
  logic [PTR_W-1:0] rear;
  logic             no_entries;
  logic [CFG_W-1:0] size_reg;
  queue_result_t    expected_results [$];

  function automatic int ring_len();
    if (size_reg == '0) return 1;
    if (size_reg > CFG_W'(DEPTH)) return DEPTH;
    return int'(size_reg);
  endfunction

  function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p);
    return (int'(p) + 1 >= ring_len()) ? '0 : p + 1'b1;
  endfunction

  function automatic logic holds_full();
    return !no_entries && step_ptr(rear) == front;
  endfunction

  // Apply one action to the predicted queue and return the result it must produce
  function automatic queue_result_t apply_action(input logic [ACT_W-1:0] act,
                                                 input logic [ID_W-1:0]  key);
    queue_result_t    r;
    logic [PTR_W-1:0] p;
    r = '0;
    case (act)
      ACT_ENQ: begin
        if (!holds_full()) begin
          if (no_entries) begin
            front      = '0;
            rear       = '0;
            no_entries = 1'b0;
          end else begin
            rear = step_ptr(rear);
          end
          id_store[rear] = key;
          r.done         = 1'b1;
        end
      end
      ACT_DEQ: begin
        if (!no_entries) begin
          if (front == rear) begin
            front      = '0;
            rear       = '0;
            no_entries = 1'b1;
          end else begin
            front = step_ptr(front);
          end
          r.done = 1'b1;
        end
      end
      ACT_FIND: begin
        if (!no_entries) begin
          p = front;
          for (int k = 0; k < DEPTH; k++) begin
            if (id_store[p] == key) begin
              r.done = 1'b1;
              r.slot = p;
              break;
            end
            if (p == rear) break;
            p = step_ptr(p);
          end
        end
      end
      default: ;
    endcase
    r.empty = no_entries;
    r.full  = holds_full();
    return r;
  endfunction

  task automatic log_fault(input string msg);
    fail_count++;
    if (fail_count <= MAX_SHOWN) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    queue_result_t got;
    queue_result_t want;
    if (!rst_ni) begin
      front      = '0;
      rear       = '0;
      no_entries = 1'b1;
      size_reg   = ACTIVE_SIZE_RST;
      expected_results.delete();
      pending_results = 0;
    end else begin
      // Retire the oldest expectation before queueing a new one
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[OUT_FLD_W-1:0];
        if (expected_results.size() == 0) begin
          log_fault($sformatf("result %h arrived with nothing expected", m_axis_tdata));
        end else begin
          want = expected_results.pop_front();
          if (got.done !== want.done || got.slot !== want.slot || got.empty !== want.empty ||
              got.full !== want.full || m_axis_tdata[OUT_TDATA_W-1:OUT_FLD_W] !== '0) begin
            log_fault($sformatf(
              "result mismatch: expected done %0b slot %0d empty %0b full %0b, got %h",
              want.done, want.slot, want.empty, want.full, m_axis_tdata));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(apply_action(s_axis_tdata[ACT_W-1:0],
                                                s_axis_tdata[ACT_W +: ID_W]));
      end
      if (psel && penable && pready && paddr == SIZE_ADDR) begin
        if (pwrite) begin
          size_reg = pwdata[CFG_W-1:0];
        end else if (prdata !== APB_DW'(size_reg)) begin
          log_fault($sformatf("size register read: expected %0d, got %0d", size_reg, prdata));
        end
      end
      pending_results = expected_results.size();
    end
  end

endmodule

/* tb/testbench.sv */
// Top of the queue testbench: clock, reset, item and register stimulus, verdict
`timescale 1ns / 100ps

module testbench;

  import cqs_pkg::*;

  localparam logic [ACT_W-1:0]  ACT_NOP       = 2'd3;   // unused action code
  localparam logic [APB_AW-1:0] SIZE_ADDR     = APB_AW'(4 * int'(REG_ACTIVE_SIZE));
  localparam int                PHASES        = 8;
  localparam int                PHASE_ITEMS   = 85;
  localparam int                SEGMENT       = 40;     // items per fill or drain stretch
  localparam int                POOL_SIZE     = 6;
  localparam int                SETTLE_CYCLES = 20;     // longer than the slowest find
  localparam int                LONG_HOLD     = 300;
  localparam int                PRESSURE_PH   = 4;
  localparam int                TIMEOUT_NS    = 2_000_000;

  logic                    clk_i;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;     // action[1:0], user_id[32:2], zero
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;           // done[0], slot[4:1], empty[5], full[6]
  logic                    psel          = 1'b0;
  logic                    penable       = 1'b0;
  logic                    pwrite        = 1'b0;
  logic [APB_AW-1:0]       paddr         = '0;
  logic [APB_DW-1:0]       pwdata        = '0;
  logic [APB_DW-1:0]       prdata;
  logic                    pready;
  int                      fail_count;
  int                      pending_results;

  // Idling knobs, changed only between phases
  int                      send_idle_pct = 0;
  int                      stall_pct     = 0;
  logic                    hold_off      = 1'b0;

  circular_queue_with_search i_dut (.*);

  queue_result_checker i_checker (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("testbench: done, errors");
    $finish;
  end

  // Result side: stall at random, and once hold tready low for a long stretch so the
  // block fills up and back-pressures the item input
  initial begin : result_sink
    int unsigned held;
    held = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off && held < LONG_HOLD) begin
        held++;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Offer one item and hold it until the block takes it. Leave tvalid high afterwards so
  // that a back-to-back item needs no lowering in between.
  task automatic push_item(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] key);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({key, act});
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Drop tvalid and wait until every result has come back and the block has settled
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // One register access: setup cycle, then access cycle until pready
  task automatic apb_access(input logic wr, input logic [APB_DW-1:0] wdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= SIZE_ADDR;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Program the ring size, then read it back so the checker can compare it
  task automatic set_ring_size(input logic [CFG_W-1:0] sz);
    apb_access(1'b1, APB_DW'(sz));
    apb_access(1'b0, '0);
  endtask

  initial begin : stimulus
    logic [ID_W-1:0]  last_id;
    logic [ID_W-1:0]  id_pool [POOL_SIZE];
    logic [ID_W-1:0]  key;
    logic [ACT_W-1:0] act;
    logic [CFG_W-1:0] phase_size [PHASES];
    int               roll;
    logic             filling;

    // Sizes per phase: both extremes, the clamped values below and above the range,
    // and a few in between
    phase_size = '{5'd1, 5'd0, 5'd31, 5'd2, 5'd16, 5'd5, 5'd3, 5'd16};

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Rewrite the reset size so the first phase runs with the whole store
    set_ring_size(5'd16);

    // Directed part: actions on an empty queue, extreme ids, then fill every slot so that
    // later resizes with entries held never make a find look at an unwritten slot
    push_item(ACT_DEQ, 31'd0);                // dequeue when empty
    push_item(ACT_FIND, 31'd5);               // find when empty
    push_item(ACT_NOP, 31'h7FFF_FFFF);        // unused action
    push_item(ACT_ENQ, 31'd0);                // enqueue into empty queue
    push_item(ACT_ENQ, 31'h7FFF_FFFF);
    push_item(ACT_FIND, 31'h7FFF_FFFF);
    push_item(ACT_FIND, 31'd0);
    push_item(ACT_FIND, 31'h2AAA_AAAA);       // no match
    for (int k = 0; k < DEPTH - 2; k++) begin
      last_id = ID_W'($urandom);
      push_item(ACT_ENQ, last_id);
    end
    push_item(ACT_ENQ, 31'h5555_5555);        // enqueue when full: dropped
    push_item(ACT_FIND, last_id);             // match in the last slot
    push_item(ACT_FIND, 31'h5555_5555);
    push_item(ACT_DEQ, 31'd0);
    wait_idle();

    // Random part: each phase has its own size, idling mode and id pool
    for (int ph = 0; ph < PHASES; ph++) begin
      set_ring_size(phase_size[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 78; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 78; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      hold_off = (ph == PRESSURE_PH);

      // A small pool of ids makes finds hit, often more than one copy
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (int k = 2; k < POOL_SIZE; k++) id_pool[k] = ID_W'($urandom);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Alternate stretches that fill the queue up and stretches that drain it
        filling = ((n / SEGMENT) % 2) == 0;
        roll    = $urandom_range(0, 99);
        if (roll < 5) begin
          act = ACT_NOP;
        end else if (roll < 35) begin
          act = ACT_FIND;
        end else if (roll < (filling ? 90 : 45)) begin
          act = ACT_ENQ;
        end else begin
          act = ACT_DEQ;
        end
        key = ($urandom_range(0, 99) < 70) ? id_pool[$urandom_range(0, POOL_SIZE - 1)]
                                           : ID_W'($urandom);
        push_item(act, key);
      end
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
